/* hw/rtl/websocket_frame_deframer_defines.svh */
// ----------------------------------------------------------------------------
// WebSocket frame deframer assertion macros
// Shared concurrent assertion forms for the deframer RTL.
// ----------------------------------------------------------------------------
`ifndef WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH
`define WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WSFD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define WSFD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/wsfd_pkg.sv */
// ----------------------------------------------------------------------------
// WebSocket frame deframer package
// Types and constants of the receive-side frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

package wsfd_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned LEN_W      = 64;
  localparam int unsigned KEY_W      = 32;
  localparam int unsigned OPCODE_W   = 4;
  localparam int unsigned LEFT_W     = 4;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned OUT_DATA_W = 80;

  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  localparam logic [LEFT_W-1:0] EXT16_BYTES = 4'd2;
  localparam logic [LEFT_W-1:0] EXT64_BYTES = 4'd8;
  localparam logic [LEFT_W-1:0] KEY_BYTES   = 4'd4;

  typedef enum logic [2:0] {
    PH_FIRST   = 3'd0,
    PH_SECOND  = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_MASKKEY = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_HALTED  = 3'd5
  } phase_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_HEADER  = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_t;

endpackage

`default_nettype wire

/* hw/rtl/websocket_frame_deframer.sv */
// ----------------------------------------------------------------------------
// WebSocket frame deframer
// Parses received WebSocket frames byte by byte and unmasks their payload.
// ----------------------------------------------------------------------------
// The block takes one stream byte per beat and sustains one byte per clock
// cycle while the output is not stalled. Each accepted byte sits in an input
// register while the parser state is updated, and its result, if any, is then
// registered in the output register once the output has room.
// A header result is given on the byte that completes the length; the four
// mask key bytes give no result; each payload byte gives one unmasked byte,
// with tlast on the last byte of the frame or on the header of an empty
// frame. A frame without the mask bit gives one error result, after which the
// parser drops all bytes until reset. The 64-bit payload down-counter and its
// zero test set the cycle time.
`default_nettype none

`include "websocket_frame_deframer_defines.svh"

module websocket_frame_deframer (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [wsfd_pkg::BYTE_W-1:0]        in_tdata,   // stream_byte
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // is_final_fragment, frame_opcode, payload_length, out_byte, zero fill
  output logic [wsfd_pkg::OUT_DATA_W-1:0]         out_tdata,
  output logic [wsfd_pkg::KIND_W-1:0]             out_tuser,  // result_kind
  output logic                                    out_tlast   // last_of_frame
);

  logic                             s1_valid_r;
  logic [wsfd_pkg::BYTE_W-1:0]      s1_byte_r;

  wsfd_pkg::phase_t                 phase_r, phase_nxt;
  logic                             fin_r, fin_nxt;
  logic [wsfd_pkg::OPCODE_W-1:0]    opcode_r, opcode_nxt;
  logic                             mask_r, mask_nxt;
  logic [wsfd_pkg::LEFT_W-1:0]      left_r, left_nxt;
  logic [wsfd_pkg::LEN_W-1:0]       len_r, len_nxt;
  logic [wsfd_pkg::KEY_W-1:0]       key_r, key_nxt;
  logic [1:0]                       key_idx_r, key_idx_nxt;
  logic [wsfd_pkg::LEN_W-1:0]       remain_r, remain_nxt;

  logic                             res_vld;
  wsfd_pkg::kind_t                  res_kind;
  logic [wsfd_pkg::LEN_W-1:0]       res_len;
  logic [wsfd_pkg::BYTE_W-1:0]      res_byte;
  logic                             res_last;
  logic                             len_done;
  logic                             advance;

  logic                             out_valid_r;
  wsfd_pkg::kind_t                  out_kind_r;
  logic                             out_fin_r;
  logic [wsfd_pkg::OPCODE_W-1:0]    out_opcode_r;
  logic [wsfd_pkg::LEN_W-1:0]       out_len_r;
  logic [wsfd_pkg::BYTE_W-1:0]      out_byte_r;
  logic                             out_last_r;

  always_comb begin
    phase_nxt   = phase_r;
    fin_nxt     = fin_r;
    opcode_nxt  = opcode_r;
    mask_nxt    = mask_r;
    left_nxt    = left_r;
    len_nxt     = len_r;
    key_nxt     = key_r;
    key_idx_nxt = key_idx_r;
    remain_nxt  = remain_r;
    len_done    = 1'b0;
    res_vld     = 1'b0;
    res_kind    = wsfd_pkg::KIND_HEADER;
    res_len     = '0;
    res_byte    = '0;
    res_last    = 1'b0;
    case (phase_r)
      wsfd_pkg::PH_FIRST: begin
        fin_nxt    = s1_byte_r[7];
        opcode_nxt = s1_byte_r[3:0];
        phase_nxt  = wsfd_pkg::PH_SECOND;
      end
      wsfd_pkg::PH_SECOND: begin
        mask_nxt = s1_byte_r[7];
        len_nxt  = '0;
        if (s1_byte_r[6:0] == wsfd_pkg::LEN_EXT16) begin
          left_nxt  = wsfd_pkg::EXT16_BYTES;
          phase_nxt = wsfd_pkg::PH_EXTLEN;
        end else if (s1_byte_r[6:0] == wsfd_pkg::LEN_EXT64) begin
          left_nxt  = wsfd_pkg::EXT64_BYTES;
          phase_nxt = wsfd_pkg::PH_EXTLEN;
        end else begin
          len_nxt  = {{(wsfd_pkg::LEN_W-7){1'b0}}, s1_byte_r[6:0]};
          len_done = 1'b1;
        end
      end
      wsfd_pkg::PH_EXTLEN: begin
        len_nxt  = {len_r[wsfd_pkg::LEN_W-wsfd_pkg::BYTE_W-1:0], s1_byte_r};
        left_nxt = left_r - 4'd1;
        len_done = (left_nxt == '0);
      end
      wsfd_pkg::PH_MASKKEY: begin
        key_nxt  = {key_r[wsfd_pkg::KEY_W-wsfd_pkg::BYTE_W-1:0], s1_byte_r};
        left_nxt = left_r - 4'd1;
        if (left_nxt == '0) begin
          phase_nxt = (remain_r != '0) ? wsfd_pkg::PH_PAYLOAD : wsfd_pkg::PH_FIRST;
        end
      end
      wsfd_pkg::PH_PAYLOAD: begin
        key_idx_nxt = key_idx_r + 2'd1;
        remain_nxt  = remain_r - 64'd1;
        if (remain_nxt == '0) begin
          phase_nxt = wsfd_pkg::PH_FIRST;
        end
        res_vld  = 1'b1;
        res_kind = wsfd_pkg::KIND_PAYLOAD;
        res_byte = s1_byte_r ^ key_r[{~key_idx_r, 3'b000} +: wsfd_pkg::BYTE_W];
        res_last = (remain_nxt == '0);
      end
      default: begin
      end
    endcase
    if (len_done) begin
      res_vld = 1'b1;
      res_len = len_nxt;
      if (!mask_nxt) begin
        phase_nxt = wsfd_pkg::PH_HALTED;
        res_kind  = wsfd_pkg::KIND_ERROR;
        res_last  = 1'b1;
      end else begin
        remain_nxt  = len_nxt;
        key_nxt     = '0;
        key_idx_nxt = 2'd0;
        left_nxt    = wsfd_pkg::KEY_BYTES;
        phase_nxt   = wsfd_pkg::PH_MASKKEY;
        res_kind    = wsfd_pkg::KIND_HEADER;
        res_last    = (len_nxt == '0);
      end
    end
  end

  assign advance   = s1_valid_r && (!res_vld || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= wsfd_pkg::PH_FIRST;
    end else if (advance) begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      fin_r     <= fin_nxt;
      opcode_r  <= opcode_nxt;
      mask_r    <= mask_nxt;
      left_r    <= left_nxt;
      len_r     <= len_nxt;
      key_r     <= key_nxt;
      key_idx_r <= key_idx_nxt;
      remain_r  <= remain_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && res_vld) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_vld) begin
      out_kind_r   <= res_kind;
      out_fin_r    <= fin_r;
      out_opcode_r <= opcode_r;
      out_len_r    <= res_len;
      out_byte_r   <= res_byte;
      out_last_r   <= res_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {3'b000, out_byte_r, out_len_r, out_opcode_r, out_fin_r};

  `WSFD_ASSERT_NEXT(a_halt_sticky, clk, rst_n, phase_r == wsfd_pkg::PH_HALTED,
    phase_r == wsfd_pkg::PH_HALTED, "Parser left the halted state.")
  `WSFD_ASSERT_IMPL(a_payload_nonzero, clk, rst_n, phase_r == wsfd_pkg::PH_PAYLOAD,
    remain_r != '0, "Payload phase entered with nothing left to receive.")
  `WSFD_ASSERT_IMPL(a_field_count, clk, rst_n,
    phase_r == wsfd_pkg::PH_EXTLEN || phase_r == wsfd_pkg::PH_MASKKEY,
    left_r != '0, "Header field byte count is zero inside a field.")
  `WSFD_ASSERT_IMPL(a_error_last, clk, rst_n,
    out_valid_r && out_kind_r == wsfd_pkg::KIND_ERROR,
    out_last_r && phase_r == wsfd_pkg::PH_HALTED,
    "Error beat is not last or parser is not halted.")

endmodule

`default_nettype wire

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// WebSocket frame deframer testbench
// Streams masked frames with random headers, lengths, keys and payload into
// the deframer under random gaps and back-pressure. Every accepted byte is run
// through a local frame parser, and each result beat from the block is checked
// field by field against the oldest predicted beat. The run ends with an
// unmasked frame that halts the parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int LONG_HOLD      = 100;
  localparam int CALM_TAIL      = 60;

  typedef struct packed {
    wsfd_pkg::kind_t kind;
    logic            fin;
    logic [3:0]      opcode;
    logic [63:0]     length;
    logic [7:0]      data;
    logic            last;
  } frame_beat_t;

  typedef struct {
    logic [7:0] data;
    bit         drain_first;
  } tx_byte_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [wsfd_pkg::BYTE_W-1:0]     in_tdata = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [wsfd_pkg::OUT_DATA_W-1:0] out_tdata;
  logic [wsfd_pkg::KIND_W-1:0]     out_tuser;
  logic                            out_tlast;

  tx_byte_t    tx_bytes[$];
  frame_beat_t awaited_results[$];

  int unsigned n_predicted = 0;
  int unsigned n_checked = 0;
  int unsigned errors = 0;
  int          gap_left = 0;
  int          hold_left = 0;
  bit          long_hold_done = 1'b0;
  bit          calm = 1'b0;
  int          quiet_cycles = 0;

  wsfd_pkg::phase_t ph_q = wsfd_pkg::PH_FIRST;
  logic        fin_q = 1'b0;
  logic [3:0]  opc_q = '0;
  logic        mask_q = 1'b0;
  logic [3:0]  left_q = '0;
  logic [63:0] len_q = '0;
  logic [31:0] key_q = '0;
  logic [1:0]  key_idx_q = '0;
  logic [63:0] remaining_q = '0;

  websocket_frame_deframer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic bit deframe_byte(input logic [7:0] b, output frame_beat_t r);
    bit         len_complete;
    logic [7:0] k;
    len_complete = 1'b0;
    r = '0;
    deframe_byte = 1'b0;
    case (ph_q)
      wsfd_pkg::PH_FIRST: begin
        fin_q = b[7];
        opc_q = b[3:0];
        ph_q = wsfd_pkg::PH_SECOND;
      end
      wsfd_pkg::PH_SECOND: begin
        mask_q = b[7];
        len_q = '0;
        if (b[6:0] == wsfd_pkg::LEN_EXT16) begin
          left_q = wsfd_pkg::EXT16_BYTES;
          ph_q = wsfd_pkg::PH_EXTLEN;
        end else if (b[6:0] == wsfd_pkg::LEN_EXT64) begin
          left_q = wsfd_pkg::EXT64_BYTES;
          ph_q = wsfd_pkg::PH_EXTLEN;
        end else begin
          len_q = 64'(b[6:0]);
          len_complete = 1'b1;
        end
      end
      wsfd_pkg::PH_EXTLEN: begin
        len_q = {len_q[55:0], b};
        left_q = left_q - 4'd1;
        if (left_q == '0) len_complete = 1'b1;
      end
      wsfd_pkg::PH_MASKKEY: begin
        key_q = {key_q[23:0], b};
        left_q = left_q - 4'd1;
        if (left_q == '0) begin
          ph_q = (remaining_q != '0) ? wsfd_pkg::PH_PAYLOAD : wsfd_pkg::PH_FIRST;
        end
      end
      wsfd_pkg::PH_PAYLOAD: begin
        k = 8'(key_q >> (8 * (3 - key_idx_q)));
        key_idx_q = key_idx_q + 2'd1;
        remaining_q = remaining_q - 64'd1;
        if (remaining_q == '0) ph_q = wsfd_pkg::PH_FIRST;
        r.kind = wsfd_pkg::KIND_PAYLOAD;
        r.data = b ^ k;
        r.last = (remaining_q == '0);
        deframe_byte = 1'b1;
      end
      default: ;
    endcase
    if (len_complete) begin
      r.length = len_q;
      if (!mask_q) begin
        ph_q = wsfd_pkg::PH_HALTED;
        r.kind = wsfd_pkg::KIND_ERROR;
        r.last = 1'b1;
      end else begin
        remaining_q = len_q;
        key_q = '0;
        key_idx_q = '0;
        left_q = wsfd_pkg::KEY_BYTES;
        ph_q = wsfd_pkg::PH_MASKKEY;
        r.kind = wsfd_pkg::KIND_HEADER;
        r.last = (len_q == '0);
      end
      deframe_byte = 1'b1;
    end
    r.fin = fin_q;
    r.opcode = opc_q;
  endfunction

  task automatic push_byte(input logic [7:0] b, input bit drain_first = 1'b0);
    tx_byte_t t;
    t.data = b;
    t.drain_first = drain_first;
    tx_bytes.push_back(t);
  endtask

  // len_form: 0 for the 7-bit length, 1 for the 16-bit and 2 for the 64-bit extension.
  task automatic push_frame(input logic [7:0] head, input bit masked, input int len_form,
                            input logic [63:0] len, input logic [31:0] key_val,
                            input bit drain_first);
    logic [7:0] mbit;
    mbit = masked ? 8'h80 : 8'h00;
    push_byte(head, drain_first);
    case (len_form)
      0: push_byte(mbit | {1'b0, len[6:0]});
      1: begin
        push_byte(mbit | {1'b0, wsfd_pkg::LEN_EXT16});
        push_byte(len[15:8]);
        push_byte(len[7:0]);
      end
      default: begin
        push_byte(mbit | {1'b0, wsfd_pkg::LEN_EXT64});
        for (int i = 7; i >= 0; i--) push_byte(len[8*i +: 8]);
      end
    endcase
    if (masked) begin
      for (int i = 3; i >= 0; i--) push_byte(key_val[8*i +: 8]);
      for (longint i = 0; i < longint'(len); i++) push_byte(8'($urandom));
    end
  endtask

  task automatic push_random_frame(input int len_form, input logic [63:0] len);
    logic [31:0] key_val;
    key_val = ($urandom_range(0, 9) == 0) ? 32'h0 : $urandom;
    push_frame(8'($urandom), 1'b1, len_form, len, key_val, $urandom_range(0, 9) == 0);
  endtask

  function automatic void check_field(input string name, input logic [63:0] exp_v,
                                      input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : drive
    frame_beat_t r;
    tx_byte_t    t;
    int          produced;
    bit          drained;
    produced = 0;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        if (deframe_byte(in_tdata, r)) begin
          awaited_results.push_back(r);
          produced = 1;
        end
      end
      n_predicted <= n_predicted + produced;
      drained = (n_predicted + produced) == n_checked;
      calm <= tx_bytes.size() < CALM_TAIL;
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_tvalid <= 1'b0;
        end else if (tx_bytes.size() == 0) begin
          in_tvalid <= 1'b0;
        end else if (tx_bytes[0].drain_first && !drained) begin
          in_tvalid <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
          gap_left <= $urandom_range(0, 4);
          in_tvalid <= 1'b0;
        end else begin
          t = tx_bytes.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= t.data;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (!long_hold_done && n_checked >= 150) begin
      long_hold_done <= 1'b1;
      hold_left <= LONG_HOLD - 1;
      out_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      hold_left <= $urandom_range(0, 4);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check
    frame_beat_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (awaited_results.size() == 0) begin
        $error("unexpected result beat: kind %0h, tdata %0h", out_tuser, out_tdata);
        errors++;
      end else begin
        e = awaited_results.pop_front();
        check_field("result_kind", 64'(e.kind), 64'(out_tuser));
        check_field("is_final_fragment", 64'(e.fin), 64'(out_tdata[0]));
        check_field("frame_opcode", 64'(e.opcode), 64'(out_tdata[4:1]));
        check_field("payload_length", e.length, out_tdata[68:5]);
        check_field("out_byte", 64'(e.data), 64'(out_tdata[76:69]));
        check_field("last_of_frame", 64'(e.last), 64'(out_tlast));
      end
      n_checked <= n_checked + 1;
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    int r;
    // Extremes of the header bytes, an empty frame, a zero key and a 16-bit length.
    push_frame(8'hFF, 1'b1, 0, 64'd0, 32'hFFFF_FFFF, 1'b0);
    push_frame(8'h00, 1'b1, 0, 64'd2, 32'h0000_0000, 1'b0);
    push_frame(8'h8A, 1'b1, 1, 64'd3, $urandom, 1'b1);

    push_random_frame(0, 64'd125);
    push_random_frame(1, 64'($urandom_range(256, 400)));
    while (tx_bytes.size() < 600) begin
      r = $urandom_range(0, 9);
      if (r < 6) push_random_frame(0, 64'($urandom_range(0, 15)));
      else if (r < 7) push_random_frame(0, 64'($urandom_range(16, 125)));
      else if (r < 8) push_random_frame(1, 64'($urandom_range(0, 40)));
      else if (r < 9) push_random_frame(2, 64'($urandom_range(0, 20)));
      else push_random_frame(0, 64'd0);
    end
    // An unmasked frame with the largest length halts the parser for good.
    push_frame(8'($urandom), 1'b0, 2, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0, 1'b1);
    for (int i = 0; i < 12; i++) push_byte(8'($urandom));

    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (tx_bytes.size() != 0 || in_tvalid || awaited_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    #1;
    if (awaited_results.size() != 0) begin
      $error("%0d predicted result beats never arrived", awaited_results.size());
      errors++;
    end
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* websocket_frame_deframer.f */
+incdir+hw/rtl
hw/rtl/wsfd_pkg.sv
hw/rtl/websocket_frame_deframer.sv
bench/testbench.sv
